@@ rtl/matrix_vector_transform_defines.svh @@
// Assertion macros shared by the matrix vector transform RTL.
`ifndef MATRIX_VECTOR_TRANSFORM_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define MVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define MVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mvt_pkg.sv @@
// Package with the types, widths and op codes of the matrix vector transform.
package mvt_pkg;

  localparam int unsigned N_DIM         = 4;
  localparam int unsigned N_ELEM        = N_DIM * N_DIM;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned PROD_W        = 2 * VAL_W;
  // Four full products summed need two extra bits.
  localparam int unsigned SUM_W         = PROD_W + 2;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_VEC4  = 2'd1,
    OP_VEC3  = 2'd2
  } op_e;

endpackage

@@ rtl/matrix_vector_transform.sv @@
// Top level of the 4x4 fixed-point matrix vector transform.
//
// Usage: the block holds a 4x4 column-major matrix in signed Q16.16 that
// resets to identity. Each input beat on the in_* channel carries an op.
// A write op stores elem_value_i at elem_index_i (column times four plus
// row) and produces no output beat. A 4-vector op multiplies the matrix by
// (x, y, z, w); a 3-vector op uses only the upper 3x3 and returns w as zero.
// An op code of three is accepted and dropped.
// Each transform produces one output beat on the out_* channel. The four
// exact products of a row are summed at full width, the fraction is
// floored and the sum is saturated to the signed 32-bit range.
// An accepted input beat reaches output valid through the input register,
// a register after the sixteen parallel 32x32 multipliers, then the
// result register after the adder trees and saturation.
// Throughput is one beat per cycle while the receiver does not stall.
// A write takes effect for the next accepted transform onward.
// When the receiver stalls, the result register holds, the stages behind
// it fill, and in_stall_o rises only once the input stage is also full.
// Reset empties the pipeline and restores the identity matrix.
`include "matrix_vector_transform_defines.svh"

module matrix_vector_transform import mvt_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [IDX_W-1:0] elem_index_i,
  input  val_t             elem_value_i,
  input  val_t             vec_x_i,
  input  val_t             vec_y_i,
  input  val_t             vec_z_i,
  input  val_t             vec_w_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output val_t             out_x_o,
  output val_t             out_y_o,
  output val_t             out_z_o,
  output val_t             out_w_o
);

  localparam val_t OneVal = val_t'(64'sd1 <<< FracBits);

  // Matrix store, column-major: element (c, r) sits at c*4+r.
  val_t  matrix_q [N_ELEM];

  // Input stage.
  logic  s1_valid_q, s1_valid_d;
  logic  s1_vec3_q;
  val_t  vec_q [N_DIM];

  // Product stage, indexed [row][column].
  logic  s2_valid_q, s2_valid_d;
  logic  s2_vec3_q;
  prod_t prod_q [N_DIM][N_DIM];
  prod_t prod_d [N_DIM][N_DIM];

  // Result stage.
  logic  out_valid_q, out_valid_d;
  val_t  row_res [N_DIM];
  val_t  res_q [N_DIM];

  logic  out_ready, s2_ready, s1_ready;
  logic  in_accept, is_xform, is_write;

  // Each stage may move when the stage ahead of it is empty or moving.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_accept  = in_valid_i && s1_ready;
  assign is_xform   = (op_i == OP_VEC4) || (op_i == OP_VEC3);
  assign is_write   = (op_i == OP_WRITE);

  assign s1_valid_d  = s1_ready ? (in_accept && is_xform) : s1_valid_q;
  assign s2_valid_d  = s2_ready ? s1_valid_q : s2_valid_q;
  assign out_valid_d = out_ready ? s2_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The matrix resets to identity and takes one element per write beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < N_DIM; c++) begin
        for (int r = 0; r < N_DIM; r++) begin
          matrix_q[c*N_DIM + r] <= (c == r) ? OneVal : '0;
        end
      end
    end else if (in_accept && is_write) begin
      matrix_q[elem_index_i] <= elem_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && is_xform) begin
      s1_vec3_q <= (op_i == OP_VEC3);
      vec_q[0]  <= vec_x_i;
      vec_q[1]  <= vec_y_i;
      vec_q[2]  <= vec_z_i;
      vec_q[3]  <= vec_w_i;
    end
  end

  // Sixteen independent 32x32 products; the last column drops out for 3-vectors.
  always_comb begin
    for (int r = 0; r < N_DIM; r++) begin
      for (int c = 0; c < N_DIM; c++) begin
        if ((c == N_DIM - 1) && s1_vec3_q) begin
          prod_d[r][c] = '0;
        end else begin
          prod_d[r][c] = matrix_q[c*N_DIM + r] * vec_q[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_vec3_q <= s1_vec3_q;
      prod_q    <= prod_d;
    end
  end

  for (genvar r = 0; r < N_DIM; r++) begin : g_row
    mvt_row_sat #(
      .FracBits (FracBits)
    ) u_row (
      .prod_i (prod_q[r]),
      .res_o  (row_res[r])
    );
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_ready) begin
      res_q[0] <= row_res[0];
      res_q[1] <= row_res[1];
      res_q[2] <= row_res[2];
      // A 3-vector has no fourth row.
      res_q[3] <= s2_vec3_q ? '0 : row_res[3];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign out_w_o     = res_q[3];

  // The input side only stalls when the input stage holds a beat.
  `MVT_ASSERT_NOW(a_stall_needs_full, in_stall_o, s1_valid_q, "stall with empty input stage")
  // Writes and dropped ops never occupy the pipeline.
  `MVT_ASSERT_NEXT(a_write_no_beat, in_accept && !is_xform, !s1_valid_q, "non-transform entered pipe")
  // A write beat lands in the addressed element.
  `MVT_ASSERT_NEXT(a_write_lands, in_accept && is_write, matrix_q[$past(elem_index_i)] == $past(elem_value_i), "matrix write lost")
  // A 3-vector result leaves with w forced to zero.
  `MVT_ASSERT_NEXT(a_vec3_w_zero, s2_valid_q && s2_vec3_q && out_ready, out_w_o == '0, "3-vector w not zero")

endmodule

@@ rtl/mvt_row_sat.sv @@
// One result row: sums four products, floors the fraction and saturates to 32 bits.
module mvt_row_sat import mvt_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  prod_t prod_i [N_DIM],
  output val_t  res_o
);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] shifted;
  logic                    in_range;

  always_comb begin
    sum = '0;
    for (int c = 0; c < N_DIM; c++) begin
      sum = sum + SUM_W'(prod_i[c]);
    end
    // Arithmetic shift drops the fraction toward minus infinity.
    shifted  = sum >>> FracBits;
    in_range = (&shifted[SUM_W-1:VAL_W-1]) || !(|shifted[SUM_W-1:VAL_W-1]);
    if (in_range) begin
      res_o = shifted[VAL_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      res_o = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

endmodule
